// ===== hw/rtl/fm_discriminator_iq_core_defines.svh =====
// Assertion macros shared by the FM discriminator RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef FM_DISCRIMINATOR_IQ_CORE_DEFINES_SVH
`define FM_DISCRIMINATOR_IQ_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FMD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define FMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fmd_pkg.sv =====
// Package for the FM discriminator: widths, multiplier op codes and the
// control/result structs passed between the core, the MAC and the divider.
`timescale 1ns / 1ps
package fmd_pkg;

	localparam int SAMPLE_WIDTH  = 16;
	localparam int OUT_FRAC_BITS = 12;
	localparam int IN_W          = 16;
	localparam int OUT_W         = 16;

	localparam int PROD_W = 2 * SAMPLE_WIDTH;
	localparam int NUM_W  = 2 * SAMPLE_WIDTH + 1;
	localparam int MAG_W  = 2 * SAMPLE_WIDTH;
	localparam int DEN_W  = 2 * SAMPLE_WIDTH;

	// quotient with one extra fraction bit for rounding, wide enough to see saturation
	localparam int QUOT_W    = OUT_W + 1;
	localparam int PRE_SH    = QUOT_W - OUT_FRAC_BITS - 1;
	localparam int DIV_CNT_W = $clog2(QUOT_W);
	localparam int RND_W     = OUT_W + 1;

	localparam logic [RND_W-1:0] OUT_MAX_MAG = RND_W'((1 << (OUT_W - 1)) - 1);
	localparam logic [RND_W-1:0] OUT_MIN_MAG = RND_W'(1 << (OUT_W - 1));
	localparam logic [OUT_W-1:0] SAT_POS     = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic [OUT_W-1:0] SAT_NEG     = {1'b1, {(OUT_W - 1){1'b0}}};

	// products in issue order; num = q*prev_i - i*prev_q, den = i*i + q*q
	typedef enum logic [1:0] {
		OP_QPI = 2'd0,
		OP_IPQ = 2'd1,
		OP_II  = 2'd2,
		OP_QQ  = 2'd3
	} mul_op_t;

	typedef struct packed {
		logic    en;
		mul_op_t op;
	} mac_ctl_t;

	typedef struct packed {
		logic              done;
		logic              ovf;
		logic [QUOT_W-1:0] quot;
	} div_res_t;

endpackage

// ===== hw/rtl/fm_discriminator_iq_core.sv =====
// FM quadrature discriminator: (q*prev_i - i*prev_q) / (i^2 + q^2), rounded, saturated Q3.12.
// The 17-step restoring divider follows 4 passes through one shared multiplier; a zero
// magnitude skips the divider, and an overflow skips its divide steps.
// One item in flight; in_ready returns once the result is registered.
// arst_n clears control state and the previous I/Q sample to zero.
`timescale 1ns / 1ps
module fm_discriminator_iq_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [fmd_pkg::IN_W-1:0] i_sample,
	input  logic signed [fmd_pkg::IN_W-1:0] q_sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [fmd_pkg::OUT_W-1:0] freq_dev,
	output logic                            saturated,
	output logic                            zero_magnitude
);
	import fmd_pkg::*;
	`include "fm_discriminator_iq_core_defines.svh"

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MUL   = 6'b000010,
		S_DRAIN = 6'b000100,
		S_DIVGO = 6'b001000,
		S_DIV   = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t                         st_q;
	logic [1:0]                     op_cnt_q;
	logic signed [SAMPLE_WIDTH-1:0] cur_i_q, cur_q_q, prev_i_q, prev_q_q;
	logic                           neg_q, zero_q;
	logic                           out_valid_q;
	logic signed [OUT_W-1:0]        freq_dev_q;
	logic                           sat_q, zmag_q;

	mac_ctl_t                       mac_ctl;
	logic signed [NUM_W-1:0]        num;
	logic        [DEN_W-1:0]        den;
	logic        [NUM_W-1:0]        num_neg;
	logic        [MAG_W-1:0]        mag;
	logic                           div_start;
	div_res_t                       div_res;

	logic                           in_xfer, out_free;
	logic [RND_W-1:0]               rnd, rnd_neg;
	logic [OUT_W-1:0]               res_val;
	logic                           res_sat;

	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (st_q == S_IDLE);

	assign mac_ctl.en = (st_q == S_MUL);
	assign mac_ctl.op = mul_op_t'(op_cnt_q);

	fmd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.cur_i  (cur_i_q),
		.cur_q  (cur_q_q),
		.prev_i (prev_i_q),
		.prev_q (prev_q_q),
		.num    (num),
		.den    (den)
	);

	assign num_neg   = -num;
	assign mag       = num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
	assign div_start = (st_q == S_DIVGO) && (den != '0);

	fmd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (den),
		.res      (div_res)
	);

	// round half away from zero on the magnitude, then clip
	assign rnd     = RND_W'(({1'b0, div_res.quot} + (QUOT_W + 1)'(1)) >> 1);
	assign rnd_neg = -rnd;

	always_comb begin
		res_val = '0;
		res_sat = 1'b0;
		if (zero_q) begin
			res_val = '0;
		end else if (!neg_q) begin
			if (div_res.ovf || rnd > OUT_MAX_MAG) begin
				res_val = SAT_POS;
				res_sat = 1'b1;
			end else begin
				res_val = rnd[OUT_W-1:0];
			end
		end else begin
			if (div_res.ovf || rnd > OUT_MIN_MAG) begin
				res_val = SAT_NEG;
				res_sat = 1'b1;
			end else begin
				res_val = rnd_neg[OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			op_cnt_q    <= '0;
			out_valid_q <= 1'b0;
			prev_i_q    <= '0;
			prev_q_q    <= '0;
		end else begin
			if (st_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_cnt_q <= '0;
						st_q     <= S_MUL;
					end
				end
				S_MUL: begin
					op_cnt_q <= op_cnt_q + 1'b1;
					if (op_cnt_q == 2'(OP_QQ)) begin
						st_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// all products issued; current sample becomes the previous one
					prev_i_q <= cur_i_q;
					prev_q_q <= cur_q_q;
					st_q     <= S_DIVGO;
				end
				S_DIVGO: begin
					st_q <= (den == '0) ? S_FIN : S_DIV;
				end
				S_DIV: begin
					if (div_res.done) begin
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_i_q <= i_sample[SAMPLE_WIDTH-1:0];
			cur_q_q <= q_sample[SAMPLE_WIDTH-1:0];
		end
		if (st_q == S_DIVGO) begin
			neg_q  <= num[NUM_W-1];
			zero_q <= (den == '0);
		end
		if (st_q == S_FIN && out_free) begin
			freq_dev_q <= res_val;
			sat_q      <= res_sat;
			zmag_q     <= zero_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign freq_dev       = freq_dev_q;
	assign saturated      = sat_q;
	assign zero_magnitude = zmag_q;

	`FMD_ASSERT_NEXT(a_busy_after_xfer, in_valid && in_ready, !in_ready,
		"input taken while an item is in flight")
	`FMD_ASSERT_NOW(a_zero_clean, out_valid && zero_magnitude, freq_dev == '0 && !saturated,
		"zero magnitude result not cleared")
	`FMD_ASSERT_NOW(a_done_in_div, div_res.done, st_q == S_DIV,
		"divider finished outside the divide phase")
	`FMD_ASSERT_NOW(a_start_nonzero, div_start, den != '0, "divider started with zero divisor")

endmodule

// ===== hw/rtl/fmd_mac.sv =====
// Shared signed multiplier with registered product and num/den accumulators.
// Depends on fmd_pkg.
`timescale 1ns / 1ps
module fmd_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fmd_pkg::mac_ctl_t                      ctl,
	input  logic signed [fmd_pkg::SAMPLE_WIDTH-1:0] cur_i,
	input  logic signed [fmd_pkg::SAMPLE_WIDTH-1:0] cur_q,
	input  logic signed [fmd_pkg::SAMPLE_WIDTH-1:0] prev_i,
	input  logic signed [fmd_pkg::SAMPLE_WIDTH-1:0] prev_q,
	output logic signed [fmd_pkg::NUM_W-1:0]        num,
	output logic        [fmd_pkg::DEN_W-1:0]        den
);
	import fmd_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] opa, opb;
	logic signed [PROD_W-1:0]       prod_s1;
	logic signed [NUM_W-1:0]        prod_ext;
	mul_op_t                        op_s1;
	logic                           vld_s1;
	logic signed [NUM_W-1:0]        num_q;
	logic        [DEN_W-1:0]        den_q;

	always_comb begin
		case (ctl.op)
			OP_QPI: begin
				opa = cur_q;
				opb = prev_i;
			end
			OP_IPQ: begin
				opa = cur_i;
				opb = prev_q;
			end
			OP_II: begin
				opa = cur_i;
				opb = cur_i;
			end
			OP_QQ: begin
				opa = cur_q;
				opb = cur_q;
			end
			default: begin
				opa = cur_i;
				opb = cur_i;
			end
		endcase
	end

	assign prod_ext = {prod_s1[PROD_W-1], prod_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_s1 <= opa * opb;
			op_s1   <= ctl.op;
		end
		if (vld_s1) begin
			case (op_s1)
				OP_QPI:  num_q <= prod_ext;
				OP_IPQ:  num_q <= num_q - prod_ext;
				OP_II:   den_q <= DEN_W'(prod_s1);
				OP_QQ:   den_q <= den_q + DEN_W'(prod_s1);
				default: num_q <= num_q;
			endcase
		end
	end

	assign num = num_q;
	assign den = den_q;

endmodule

// ===== hw/rtl/fmd_div.sv =====
// Restoring divider, one quotient bit per cycle through one shared subtractor.
// Computes floor(dividend * 2^(OUT_FRAC_BITS+1) / divisor); flags overflow. Depends on fmd_pkg.
`timescale 1ns / 1ps
module fmd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fmd_pkg::MAG_W-1:0]   dividend,
	input  logic [fmd_pkg::DEN_W-1:0]   divisor,
	output fmd_pkg::div_res_t           res
);
	import fmd_pkg::*;
	`include "fm_discriminator_iq_core_defines.svh"

	logic                 busy_q, done_q, ovf_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     den_q, rem_q;
	logic [QUOT_W-1:0]    dvd_q, quot_q;
	logic [DEN_W:0]       trial;
	logic [DEN_W+1:0]     diff;
	logic                 fit;
	logic                 ovf_in;

	// quotient would need more than QUOT_W bits: saturates anyway
	assign ovf_in = {{PRE_SH{1'b0}}, dividend} >= {divisor, {PRE_SH{1'b0}}};

	assign trial = {rem_q, dvd_q[QUOT_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign fit   = !diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ovf_q <= ovf_in;
				if (ovf_in) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= DIV_CNT_W'(QUOT_W - 1);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= divisor;
			rem_q  <= DEN_W'(dividend >> PRE_SH);
			dvd_q  <= QUOT_W'({dividend, {(OUT_FRAC_BITS + 1){1'b0}}});
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			dvd_q  <= {dvd_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], fit};
		end
	end

	assign res.done = done_q;
	assign res.ovf  = ovf_q;
	assign res.quot = quot_q;

	`FMD_ASSERT_NOW(a_div_start_idle, start, !busy_q, "divider started while busy")
	`FMD_ASSERT_NOW(a_div_rem_bound, busy_q, rem_q < den_q, "partial remainder not below divisor")
	`FMD_ASSERT_NEXT(a_div_last_step, busy_q && cnt_q == '0 && !start, done_q && !busy_q,
		"divider did not finish after last step")

endmodule
